[rtl/core/jrp_pkg.sv]
// Shared types, widths and arithmetic helpers for the Jacobi rotation pair block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jrp_pkg;

  // Data and coefficient formats
  localparam int DATA_WIDTH      = 32;
  localparam int COEF_FRAC_BITS  = 30;
  localparam int COEF_WIDTH      = COEF_FRAC_BITS + 2;   // tangent, signed
  localparam int COS_WIDTH       = COEF_FRAC_BITS + 1;   // cosine, unsigned
  localparam int PROD_WIDTH      = DATA_WIDTH + COEF_WIDTH;
  localparam int SUM_WIDTH       = DATA_WIDTH + 1;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = COEF_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COSINE    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TANGENT   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SWAP_MODE = 2'd2;

  // Cosine of exactly 1.0
  localparam logic [COS_WIDTH-1:0] COS_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};

  // Rounding and saturation constants
  localparam logic signed [PROD_WIDTH-1:0] ROUND_HALF =
    {{(PROD_WIDTH-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [PROD_WIDTH-1:0] PROD_DMAX =
    {{(PROD_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [PROD_WIDTH-1:0] PROD_DMIN =
    {{(PROD_WIDTH-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_DMAX =
    {2'b00, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_DMIN =
    {2'b11, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  // How the back end treats a request
  typedef enum logic [2:0] {
    CLS_ROTATE,
    CLS_ROTATE_SWAP,
    CLS_PASS,
    CLS_PASS_SWAP,
    CLS_ERROR
  } item_class_t;

  typedef struct packed {
    data_t       x;
    data_t       y;
    logic        last;
    item_class_t cls;
  } item_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] tangent;
    logic [COS_WIDTH-1:0]         cosine;
  } coef_t;

  // Round half-up a product down by COEF_FRAC_BITS, saturate to the data width
  function automatic data_t round_sat(input prod_t p);
    prod_t r;
    prod_t sh;
    r  = p + ROUND_HALF;
    sh = r >>> COEF_FRAC_BITS;
    if (sh > PROD_DMAX) begin
      return DMAX;
    end else if (sh < PROD_DMIN) begin
      return DMIN;
    end
    return sh[DATA_WIDTH-1:0];
  endfunction

  // Saturate a sum or difference to the data width
  function automatic data_t sat_sum(input logic signed [SUM_WIDTH-1:0] v);
    if (v > SUM_DMAX) begin
      return DMAX;
    end else if (v < SUM_DMIN) begin
      return DMIN;
    end
    return v[DATA_WIDTH-1:0];
  endfunction

endpackage

[rtl/core/jacobi_rotation_pair.sv]
// Jacobi plane rotation (tangent-cosine form) on one element pair per request.
// From input acceptance, a request passes the queue, the rotation pipeline and its output register.
// Throughput: one request per cycle while out_stall is low, set by the pipelined tangent and cosine multipliers.
// A two-entry queue parts intake from the pipeline; input stalls only when it fills.
// Reset (rst, synchronous): cosine = 1.0, tangent = 0, swap_mode = 0, all stages empty.
`timescale 1ns / 1ps

module jacobi_rotation_pair
  import jrp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  data_t                      x_in,
  input  data_t                      y_in,
  input  logic                       last_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output data_t                      x_out,
  output data_t                      y_out,
  output logic                       status,
  output logic                       last_out
);

  logic  queue_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  head_valid;
  item_t head_item;
  coef_t coef;

  // Intake and classification
  jrp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .x_in         (x_in),
    .y_in         (y_in),
    .last_in      (last_in),
    .queue_full   (queue_full),
    .push         (push),
    .push_item    (push_item),
    .coef         (coef)
  );

  // Decoupling queue
  jrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Rotation pipeline
  jrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .coef       (coef),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .x_out      (x_out),
    .y_out      (y_out),
    .status     (status),
    .last_out   (last_out)
  );

endmodule

[rtl/core/jrp_front.sv]
// Front end: configuration registers, request intake and classification.
// Depends on jrp_pkg; feeds jrp_queue and hands coefficients to jrp_back.
`timescale 1ns / 1ps

module jrp_front
  import jrp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  data_t                      x_in,
  input  data_t                      y_in,
  input  logic                       last_in,
  input  logic                       queue_full,
  output logic                       push,
  output item_t                      push_item,
  output coef_t                      coef
);

  logic signed [COEF_WIDTH-1:0] tangent;
  logic [COS_WIDTH-1:0]         cosine;
  logic                         swap_mode;
  logic                         tan_zero;
  logic                         cos_one;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cosine    <= COS_ONE;
      tangent   <= '0;
      swap_mode <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_COSINE:    cosine    <= cfg_data[COS_WIDTH-1:0];
        REG_TANGENT:   tangent   <= cfg_data[COEF_WIDTH-1:0];
        REG_SWAP_MODE: swap_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Accept a request whenever the queue has room
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the request by coefficients and mode
  assign tan_zero = (tangent == '0);
  assign cos_one  = (cosine == COS_ONE);

  always_comb begin
    push_item.x    = x_in;
    push_item.y    = y_in;
    push_item.last = last_in;
    priority if (!tan_zero) begin
      push_item.cls = swap_mode ? CLS_ROTATE_SWAP : CLS_ROTATE;
    end else if (!cos_one) begin
      push_item.cls = CLS_ERROR;
    end else begin
      push_item.cls = swap_mode ? CLS_PASS_SWAP : CLS_PASS;
    end
  end

  assign coef.tangent = tangent;
  assign coef.cosine  = cosine;

endmodule

[rtl/core/jrp_queue.sv]
// Two-entry request queue between the front end and the back end.
// Depends on jrp_pkg for the queued item type.
`timescale 1ns / 1ps

module jrp_queue
  import jrp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[rd_ptr];

endmodule

[rtl/core/jrp_back.sv]
// Back end: five-stage rotation pipeline whose last stage is the output register.
// Depends on jrp_pkg for formats and rounding helpers; drains jrp_queue.
`timescale 1ns / 1ps

module jrp_back
  import jrp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  item_t head_item,
  output logic  pop,
  input  coef_t coef,
  output logic  out_valid,
  input  logic  out_stall,
  output data_t x_out,
  output data_t y_out,
  output logic  status,
  output logic  last_out
);

  // Stage valids and enables: index 1..4 internal, out_valid is stage 5
  logic  v1, v2, v3, v4;
  logic  en1, en2, en3, en4, en5;

  item_t it1, it2, it3, it4;
  prod_t ty1, tx1;          // tangent products
  data_t p2, q2;            // rounded tangent products
  data_t s3, d3;            // saturated sum and difference
  prod_t ms4, md4;          // cosine products

  logic signed [COEF_WIDTH-1:0] cos_s;
  data_t plus, minus;

  assign cos_s = {1'b0, coef.cosine};

  // Each stage moves when it is empty or the next one moves
  assign en5 = !out_valid || !out_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pop = head_valid && en1;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= head_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // Stage 1: multiply by the tangent
  always_ff @(posedge clk) begin
    if (en1) begin
      it1 <= head_item;
      ty1 <= coef.tangent * head_item.y;
      tx1 <= coef.tangent * head_item.x;
    end
  end

  // Stage 2: round and saturate the tangent products
  always_ff @(posedge clk) begin
    if (en2) begin
      it2 <= it1;
      p2  <= round_sat(ty1);
      q2  <= round_sat(tx1);
    end
  end

  // Stage 3: saturating add and subtract
  always_ff @(posedge clk) begin
    if (en3) begin
      it3 <= it2;
      s3  <= sat_sum(SUM_WIDTH'($signed(it2.x)) + SUM_WIDTH'(p2));
      d3  <= sat_sum(SUM_WIDTH'($signed(it2.y)) - SUM_WIDTH'(q2));
    end
  end

  // Stage 4: multiply by the cosine
  always_ff @(posedge clk) begin
    if (en4) begin
      it4 <= it3;
      ms4 <= s3 * cos_s;
      md4 <= d3 * cos_s;
    end
  end

  // Stage 5: round, route by class and hold the result
  assign plus  = round_sat(ms4);
  assign minus = round_sat(md4);

  always_ff @(posedge clk) begin
    if (en5) begin
      last_out <= it4.last;
      unique case (it4.cls)
        CLS_ROTATE: begin
          x_out  <= plus;
          y_out  <= minus;
          status <= 1'b0;
        end
        CLS_ROTATE_SWAP: begin
          x_out  <= minus;
          y_out  <= plus;
          status <= 1'b0;
        end
        CLS_PASS_SWAP: begin
          x_out  <= it4.y;
          y_out  <= it4.x;
          status <= 1'b0;
        end
        CLS_ERROR: begin
          x_out  <= it4.x;
          y_out  <= it4.y;
          status <= 1'b1;
        end
        default: begin
          x_out  <= it4.x;
          y_out  <= it4.y;
          status <= 1'b0;
        end
      endcase
    end
  end

endmodule

[test/rotation_checker.sv]
// Scoreboard for jacobi_rotation_pair: follows the register writes, predicts each rotated
// pair from accepted requests and compares results in order. Depends on jrp_pkg only.
`timescale 1ns / 1ps

module rotation_checker
  import jrp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  data_t                      x_in,
  input  data_t                      y_in,
  input  logic                       last_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  data_t                      x_out,
  input  data_t                      y_out,
  input  logic                       status,
  input  logic                       last_out,
  output int                         pending,
  output int                         failures
);

  typedef struct {
    data_t x;
    data_t y;
    logic  status;
    logic  last;
  } rotated_pair_t;

  localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (COEF_FRAC_BITS - 1);

  // Shadow copy of the coefficient registers
  logic [COS_WIDTH-1:0]         cos_q;
  logic signed [31:0]           tan_q;
  logic                         swap_q;

  rotated_pair_t rotated_q[$];
  rotated_pair_t want;

  // Exact product scaled down by the coefficient fraction, rounded half-up, clamped
  function automatic data_t scale_round(input logic signed [63:0] a,
                                        input logic signed [63:0] b);
    logic signed [127:0] prod;
    prod = a * b;
    prod = (prod + HALF_LSB) >>> COEF_FRAC_BITS;
    if (prod > DMAX) return DMAX;
    if (prod < DMIN) return DMIN;
    return prod[DATA_WIDTH-1:0];
  endfunction

  // Sum clamped to the data range
  function automatic data_t clamp_sum(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (s > DMAX) return DMAX;
    if (s < DMIN) return DMIN;
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic rotated_pair_t rotate_pair(input data_t x, input data_t y,
                                                input logic last);
    rotated_pair_t r;
    logic signed [63:0] x64, y64, t64, c64, p, q;
    data_t plus, minus;
    x64 = x;
    y64 = y;
    t64 = tan_q;
    c64 = {33'd0, cos_q};
    r.last = last;
    r.status = 1'b0;
    if (tan_q == 0) begin
      // zero tangent: pass through; swap only when the cosine is exactly one
      if (cos_q == COS_ONE && swap_q) begin
        r.x = y;
        r.y = x;
      end else begin
        r.x = x;
        r.y = y;
        r.status = (cos_q != COS_ONE);
      end
    end else begin
      p = scale_round(t64, y64);
      q = scale_round(t64, x64);
      plus  = scale_round(clamp_sum(x64, p), c64);
      minus = scale_round(clamp_sum(y64, -q), c64);
      r.x = swap_q ? minus : plus;
      r.y = swap_q ? plus : minus;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cos_q    = COS_ONE;
      tan_q    = '0;
      swap_q   = 1'b0;
      failures = 0;
      rotated_q.delete();
    end else begin
      // track register writes
      if (cfg_write_en) begin
        case (cfg_index)
          REG_COSINE:    cos_q = cfg_data[COS_WIDTH-1:0];
          REG_TANGENT:   tan_q = cfg_data[31:0];
          REG_SWAP_MODE: swap_q = cfg_data[0];
          default: ;
        endcase
      end
      // predict each accepted request
      if (in_valid && !in_stall) begin
        rotated_q.push_back(rotate_pair(x_in, y_in, last_in));
      end
      // compare each accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (rotated_q.size() == 0) begin
          $error("result with nothing outstanding: x_out %h y_out %h", x_out, y_out);
          failures++;
        end else begin
          want = rotated_q.pop_front();
          if (x_out !== want.x) begin
            $error("x_out: expected %h, got %h", want.x, x_out);
            failures++;
          end
          if (y_out !== want.y) begin
            $error("y_out: expected %h, got %h", want.y, y_out);
            failures++;
          end
          if (status !== want.status) begin
            $error("status: expected %b, got %b", want.status, status);
            failures++;
          end
          if (last_out !== want.last) begin
            $error("last_out: expected %b, got %b", want.last, last_out);
            failures++;
          end
        end
      end
    end
    pending = rotated_q.size();
  end

endmodule

[test/testbench.sv]
// Top of the jacobi_rotation_pair testbench: clock, reset, register writes, request and
// stall stimulus, verdict. Depends on jrp_pkg, jacobi_rotation_pair and rotation_checker.
`timescale 1ns / 1ps

module testbench
  import jrp_pkg::*;
();

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 95;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write_en = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  data_t                      x_in = '0;
  data_t                      y_in = '0;
  logic                       last_in = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  data_t                      x_out;
  data_t                      y_out;
  logic                       status;
  logic                       last_out;

  int pending;
  int failures;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int settings_run = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  jacobi_rotation_pair uut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_in(x_in), .y_in(y_in), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .x_out(x_out), .y_out(y_out), .status(status), .last_out(last_out)
  );

  rotation_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_in(x_in), .y_in(y_in), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .x_out(x_out), .y_out(y_out), .status(status), .last_out(last_out),
    .pending(pending), .failures(failures)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Random back-pressure on the result side
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  // Present one request, with random idle cycles ahead of it; return once accepted
  task automatic send_pair(input data_t x, input data_t y, input logic last);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    x_in     <= x;
    y_in     <= y;
    last_in  <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    sent++;
  endtask

  // Hold off new requests until every outstanding result has come back
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(negedge clk);
  endtask

  // Load all three registers; unused upper bits get random junk
  task automatic load_coefficients(input logic [COS_WIDTH-1:0] cos_v,
                                   input logic [31:0] tan_v, input logic swap_v);
    write_reg(REG_COSINE, {1'($urandom_range(0, 1)), cos_v});
    write_reg(REG_TANGENT, tan_v);
    write_reg(REG_SWAP_MODE, {31'($urandom), swap_v});
    cfg_write_en <= 1'b0;
    @(negedge clk);
    settings_run++;
  endtask

  // Mix full-range values, extremes, values around one and mid-size values
  function automatic data_t pick_data;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: begin
        case ($urandom_range(0, 4))
          0: return DMAX;
          1: return DMIN;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      5, 6, 7: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      default: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
    endcase
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        gap_pct = 69;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct <= 69;
      end
      IDLE_BOTH: begin
        gap_pct = 26;
        stall_pct <= 26;
      end
      default: begin
        gap_pct = 0;
        stall_pct <= 0;
      end
    endcase
  endtask

  // Edges of the data range, sign patterns and a few values near one
  task automatic directed_pairs;
    send_pair('0, '0, 1'b0);
    send_pair(DMAX, DMAX, 1'b1);
    send_pair(DMIN, DMIN, 1'b0);
    send_pair(DMAX, DMIN, 1'b0);
    send_pair(DMIN, DMAX, 1'b1);
    send_pair(-1, -1, 1'b0);
    send_pair(1, -1, 1'b0);
    send_pair(-1, 1, 1'b1);
    send_pair(32'sh0100_0000, 32'sh0100_0000, 1'b0);
    send_pair(-32'sh0100_0000, 32'sh0100_0000, 1'b0);
    send_pair(32'sh5555_5555, 32'shAAAA_AAAA, 1'b1);
    send_pair(32'shAAAA_AAAA, 32'sh5555_5555, 1'b0);
  endtask

  // One coefficient setting: drain, load, then random requests with a full pause midway
  task automatic run_setting(input logic [COS_WIDTH-1:0] cos_v, input logic [31:0] tan_v,
                             input logic swap_v, input idle_mode_t mode);
    drain();
    load_coefficients(cos_v, tan_v, swap_v);
    set_idling(mode);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) drain();
      send_pair(pick_data(), pick_data(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset coefficients (plain pass-through), then cosine one with tangent -1.0
    directed_pairs();
    drain();
    load_coefficients(COS_ONE, 32'hC000_0000, 1'b0);
    directed_pairs();

    run_setting(COS_ONE, 32'h0000_0000, 1'b0, IDLE_NONE);
    run_setting(COS_ONE, 32'h0000_0000, 1'b1, IDLE_SENDER);
    run_setting(31'h2D41_3CCD, 32'h0000_0000, 1'b0, IDLE_RECEIVER);
    run_setting(31'h2D41_3CCD, 32'h4000_0000, 1'b0, IDLE_BOTH);
    run_setting(31'h2D41_3CCD, 32'hC000_0000, 1'b1, IDLE_NONE);
    run_setting('0, $urandom, 1'b0, IDLE_SENDER);
    run_setting(31'h7FFF_FFFF, 32'h8000_0000, 1'b1, IDLE_RECEIVER);
    run_setting(31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, IDLE_BOTH);
    run_setting('0, 32'h0000_0000, 1'b1, IDLE_NONE);
    run_setting(31'($urandom), $urandom, 1'($urandom_range(0, 1)), IDLE_SENDER);
    run_setting(31'($urandom_range(0, 32'h4000_0000)),
                32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000,
                1'($urandom_range(0, 1)), IDLE_RECEIVER);
    run_setting(COS_WIDTH'(COS_ONE - 1'b1), 32'h0000_0001, 1'b0, IDLE_BOTH);

    // wait out the pipeline, then keep waiting for stray results
    drain();
    repeat (16) @(negedge clk);

    $display("summary: %0d requests over %0d coefficient loads plus reset values,", sent,
             settings_run);
    $display("summary: both swap modes, zero tangent, saturation, gaps and stalls");
    if (failures == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/jrp_pkg.sv
rtl/core/jrp_front.sv
rtl/core/jrp_queue.sv
rtl/core/jrp_back.sv
rtl/core/jacobi_rotation_pair.sv
test/rotation_checker.sv
test/testbench.sv
